// ===== rtl/sector_write_combine_cache_core_macros.svh =====
// Assertion helpers for the write-combining cache core.
// Each macro expects clk and arst_n in scope.
`ifndef SECTOR_WRITE_COMBINE_CACHE_CORE_MACROS_SVH
`define SECTOR_WRITE_COMBINE_CACHE_CORE_MACROS_SVH

// same-cycle implication
`define SWCC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("swcc: same-cycle check failed");

// next-cycle implication
`define SWCC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("swcc: next-cycle check failed");

`endif

// ===== rtl/swcc_pkg.sv =====
package swcc_pkg;

	// window sizes in sectors; both must be powers of two
	localparam int unsigned WR_WIN = 32;
	localparam int unsigned RD_WIN = 32;
	localparam int unsigned WR_IW  = $clog2(WR_WIN);
	localparam int unsigned WR_CW  = $clog2(WR_WIN + 1);

	localparam logic [31:0] EMPTY_BASE = 32'hFFFF_FFFF;

	localparam logic [2:0] FUNC_STATUS   = 3'd0;
	localparam logic [2:0] FUNC_READ     = 3'd1;
	localparam logic [2:0] FUNC_WRITE    = 3'd2;
	localparam logic [2:0] FUNC_SYNC     = 3'd3;
	localparam logic [2:0] FUNC_SHUTDOWN = 3'd4;

	localparam logic [1:0] KIND_RUN    = 2'd0;
	localparam logic [1:0] KIND_FILL   = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;
	localparam logic [1:0] KIND_DATA   = 2'd3;

	localparam logic REG_TOTAL = 1'b0;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_PRE_FLUSH,
		S_MARK,
		S_SET,
		S_POST_FLUSH,
		S_FILL,
		S_REPLY
	} state_t;

	typedef struct packed {
		logic run;
		logic put_ok;
	} flush_ctl_t;

	typedef struct packed {
		logic             emit;
		logic [WR_IW-1:0] offset;
		logic [WR_CW-1:0] len;
		logic             done;
	} flush_sts_t;

	function automatic logic win_hit(logic [31:0] base, logic [31:0] start,
			logic [1:0] cnt, logic [31:0] size);
		logic [31:0] fin;
		logic [31:0] lim;
		fin = start + {30'd0, cnt};
		lim = base + size;
		return ((base & (size - 32'd1)) == 32'd0) && (start >= base) && (fin <= lim);
	endfunction

	function automatic logic [31:0] realign(logic [31:0] start, logic [1:0] cnt,
			logic [31:0] size);
		logic [31:0] b;
		b = start & ~(size - 32'd1);
		if ((start + {30'd0, cnt}) > (b + size)) begin
			b = start;
		end
		return b;
	endfunction

endpackage

// ===== rtl/swcc_ifs.sv =====
interface swcc_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  func;
	logic [31:0] start_sector;
	logic [1:0]  sector_count;

	modport source (output valid, func, start_sector, sector_count, input ready);
	modport sink (input valid, func, start_sector, sector_count, output ready);
endinterface

interface swcc_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] disk_sector;
	logic [6:0]  run_length;
	logic [5:0]  buffer_offset;
	logic        rejected;
	logic [31:0] reply_value;
	logic        last;

	modport source (output valid, kind, disk_sector, run_length, buffer_offset,
		rejected, reply_value, last, input ready);
	modport sink (input valid, kind, disk_sector, run_length, buffer_offset,
		rejected, reply_value, last, output ready);
endinterface

// ===== rtl/swcc_apb.sv =====
module swcc_apb import swcc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [31:0] disk_size
);

	logic [31:0] total_q;
	logic        wr_en;

	assign pready    = 1'b1;
	assign wr_en     = psel && penable && pwrite;
	assign disk_size = total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= 32'd0;
		end else if (wr_en && (paddr[2] == REG_TOTAL)) begin
			total_q <= pwdata;
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_TOTAL: prdata = total_q;
			default:   prdata = 32'd0;
		endcase
	end

endmodule

// ===== rtl/swcc_flush.sv =====
module swcc_flush import swcc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  flush_ctl_t        ctl,
	input  logic [WR_WIN-1:0] bits,
	output flush_sts_t        sts
);

	logic             active_q;
	logic             in_run_q;
	logic [WR_CW-1:0] idx_q;
	logic [WR_CW-1:0] len_q;
	logic [WR_IW-1:0] rs_q;
	logic             at_end;
	logic             cur_bit;
	logic             emit;
	logic             stall;

	assign at_end  = (idx_q == WR_CW'(WR_WIN));
	assign cur_bit = at_end ? 1'b0 : bits[idx_q[WR_IW-1:0]];
	// a run closes on the first clear bit after it, or at the window end
	assign emit    = active_q && in_run_q && (at_end || !cur_bit);
	assign stall   = emit && !ctl.put_ok;

	assign sts.emit   = emit;
	assign sts.offset = rs_q;
	assign sts.len    = len_q;
	assign sts.done   = active_q && at_end && !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			in_run_q <= 1'b0;
			idx_q    <= '0;
		end else if (!active_q) begin
			if (ctl.run) begin
				active_q <= 1'b1;
				in_run_q <= 1'b0;
				idx_q    <= '0;
			end
		end else if (!stall) begin
			if (at_end) begin
				active_q <= 1'b0;
				in_run_q <= 1'b0;
			end else begin
				in_run_q <= cur_bit;
				idx_q    <= idx_q + WR_CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (active_q && !stall && !at_end && cur_bit) begin
			if (!in_run_q) begin
				rs_q  <= idx_q[WR_IW-1:0];
				len_q <= WR_CW'(1);
			end else begin
				len_q <= len_q + WR_CW'(1);
			end
		end
	end

endmodule

// ===== rtl/sector_write_combine_cache_core.sv =====
// Write-combining sector cache controller. A request word (status, read, write, sync,
// shutdown) yields, in order, any merged dirty-sector write runs, at most one read-window
// fill, then one reply flagged last. Only one request is in work at a time: req.ready is
// high only while the sequencer is idle. Without a flush a request holds req.ready low
// through evaluate, then window update, fill or dirty-bit set as needed, then reply. A
// flush adds a scan of one dirty bit per cycle, held while the response side stalls; run
// words leave during the scan. Result words leave through an output register, so the next
// request can be taken while the final reply waits. The disk size register sits at APB
// byte address 0; pready is always high. Window sizes are powers of two.
`include "sector_write_combine_cache_core_macros.svh"

module sector_write_combine_cache_core import swcc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	swcc_req_if.sink    req,
	swcc_rsp_if.source  rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	state_t            state_q, state_d;
	logic [2:0]        func_q;
	logic [31:0]       start_q;
	logic [1:0]        cnt_q;
	logic [31:0]       read_base_q;
	logic [31:0]       write_base_q;
	logic [WR_WIN-1:0] dirty_q;
	logic [7:0]        total_q;
	logic [31:0]       disk_size;

	logic              out_valid_q;
	logic [1:0]        kind_q;
	logic [31:0]       disk_q;
	logic [6:0]        len_q;
	logic [5:0]        off_q;
	logic              rej_q;
	logic [31:0]       val_q;
	logic              last_q;

	logic              put_ok;
	logic              put;
	logic [1:0]        put_kind;
	logic [31:0]       put_disk;
	logic [6:0]        put_len;
	logic [5:0]        put_off;
	logic              put_rej;
	logic [31:0]       put_val;
	logic              put_last;

	flush_ctl_t        fctl;
	flush_sts_t        fsts;
	logic              in_flush;

	logic              rhit, whit, rinv, dirty_nz;
	logic [31:0]       end_w, rend, widx, rdiff;
	logic [WR_IW-1:0]  i0, i1;
	logic              set_ok, set_two;
	logic [7:0]        total_new;

	swcc_apb u_apb (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.disk_size (disk_size)
	);

	swcc_flush u_flush (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (fctl),
		.bits   (dirty_q),
		.sts    (fsts)
	);

	assign req.ready = (state_q == S_IDLE);
	assign put_ok    = !out_valid_q || rsp.ready;
	assign in_flush  = (state_q == S_PRE_FLUSH) || (state_q == S_POST_FLUSH);
	assign fctl.run    = in_flush;
	assign fctl.put_ok = put_ok;

	assign rhit     = win_hit(read_base_q, start_q, cnt_q, 32'(RD_WIN));
	assign whit     = win_hit(write_base_q, start_q, cnt_q, 32'(WR_WIN));
	assign end_w    = start_q + {30'd0, cnt_q};
	assign rend     = read_base_q + 32'(RD_WIN);
	assign rinv     = ((start_q >= read_base_q) && (start_q <= rend)) ||
		((end_w >= read_base_q) && (end_w <= rend));
	assign dirty_nz = (total_q != 8'd0);

	assign widx      = start_q - write_base_q;
	assign i0        = widx[WR_IW-1:0];
	assign i1        = i0 + WR_IW'(1);
	assign set_ok    = (widx < 32'(WR_WIN)) && !dirty_q[i0];
	assign set_two   = (cnt_q == 2'd2) && (widx < 32'(WR_WIN - 1));
	assign total_new = total_q + {6'd0, cnt_q};
	assign rdiff     = start_q - read_base_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) state_d = S_EVAL;
			end
			S_EVAL: begin
				case (func_q)
					FUNC_READ: begin
						if (rhit) state_d = S_REPLY;
						else if (dirty_nz) state_d = S_PRE_FLUSH;
						else state_d = S_MARK;
					end
					FUNC_WRITE: begin
						if (whit) state_d = S_SET;
						else if (dirty_nz) state_d = S_PRE_FLUSH;
						else state_d = S_MARK;
					end
					FUNC_SYNC: state_d = S_PRE_FLUSH;
					default:   state_d = S_REPLY;
				endcase
			end
			S_PRE_FLUSH: begin
				if (fsts.done) state_d = (func_q == FUNC_SYNC) ? S_REPLY : S_MARK;
			end
			S_MARK: begin
				state_d = (func_q == FUNC_READ) ? S_FILL : S_SET;
			end
			S_SET: begin
				if (set_ok && (total_new == 8'(WR_WIN))) state_d = S_POST_FLUSH;
				else state_d = S_REPLY;
			end
			S_POST_FLUSH: begin
				if (fsts.done) state_d = S_REPLY;
			end
			S_FILL: begin
				if (put_ok) state_d = S_REPLY;
			end
			S_REPLY: begin
				if (put_ok) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// result words
	always_comb begin
		put      = 1'b0;
		put_kind = KIND_STATUS;
		put_disk = 32'd0;
		put_len  = 7'd0;
		put_off  = 6'd0;
		put_rej  = 1'b0;
		put_val  = 32'd0;
		put_last = 1'b0;
		unique case (state_q) inside
			S_PRE_FLUSH, S_POST_FLUSH: begin
				put      = fsts.emit && put_ok;
				put_kind = KIND_RUN;
				put_disk = write_base_q + 32'(fsts.offset);
				put_len  = 7'(fsts.len);
				put_off  = 6'(fsts.offset);
			end
			S_FILL: begin
				put      = put_ok;
				put_kind = KIND_FILL;
				put_disk = read_base_q;
				put_len  = 7'(RD_WIN);
			end
			S_REPLY: begin
				put      = put_ok;
				put_last = 1'b1;
				case (func_q) inside
					FUNC_STATUS: put_val = disk_size;
					FUNC_READ: begin
						put_kind = KIND_DATA;
						put_len  = {5'd0, cnt_q};
						put_off  = rdiff[5:0];
					end
					FUNC_WRITE, FUNC_SYNC: put_val = 32'd0;
					default: put_rej = 1'b1;
				endcase
			end
			default: put = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			read_base_q  <= EMPTY_BASE;
			write_base_q <= EMPTY_BASE;
			dirty_q      <= '0;
			total_q      <= 8'd0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_EVAL && func_q == FUNC_WRITE && rinv) begin
				read_base_q <= EMPTY_BASE;
			end
			if (state_q == S_MARK) begin
				if (func_q == FUNC_READ) begin
					read_base_q <= realign(start_q, cnt_q, 32'(RD_WIN));
				end else begin
					write_base_q <= realign(start_q, cnt_q, 32'(WR_WIN));
				end
			end
			// a rewrite of a dirty first sector leaves the window alone
			if (state_q == S_SET && set_ok) begin
				dirty_q[i0] <= 1'b1;
				if (set_two) dirty_q[i1] <= 1'b1;
				total_q <= total_new;
			end
			if (in_flush && fsts.done) begin
				dirty_q <= '0;
				total_q <= 8'd0;
			end
			if (put) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_q  <= req.func;
			start_q <= req.start_sector;
			cnt_q   <= req.sector_count;
		end
		if (put) begin
			kind_q <= put_kind;
			disk_q <= put_disk;
			len_q  <= put_len;
			off_q  <= put_off;
			rej_q  <= put_rej;
			val_q  <= put_val;
			last_q <= put_last;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.kind          = kind_q;
	assign rsp.disk_sector   = disk_q;
	assign rsp.run_length    = len_q;
	assign rsp.buffer_offset = off_q;
	assign rsp.rejected      = rej_q;
	assign rsp.reply_value   = val_q;
	assign rsp.last          = last_q;

	`SWCC_ASSERT_NXT(a_flush_clears, in_flush && fsts.done, total_q == 8'd0 && dirty_q == '0)
	`SWCC_ASSERT_NXT(a_accept_evals, req.valid && req.ready, state_q == S_EVAL)
	`SWCC_ASSERT_IMP(a_run_shape, rsp.valid && rsp.kind == KIND_RUN, rsp.run_length != 7'd0 && !rsp.last)

endmodule

// ===== test/sector_write_combine_cache_core_tb.sv =====
module sector_write_combine_cache_core_tb;
	import swcc_pkg::*;

	localparam logic [2:0] FUNC_LAST = 3'd7;
	localparam logic [2:0] TOTAL_ADDR = 3'(4 * REG_TOTAL);
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = WR_WIN + 8;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] disk_sector;
		logic [6:0]  run_length;
		logic [5:0]  buffer_offset;
		logic        rejected;
		logic [31:0] reply_value;
		logic        last;
	} cache_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	swcc_req_if req_ch ();
	swcc_rsp_if rsp_ch ();

	sector_write_combine_cache_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// predicted cache state
	logic [31:0]        cache_total;
	logic [31:0]        rd_base;
	logic [31:0]        wr_base;
	logic [WR_WIN-1:0]  dirty_map;
	logic [7:0]         dirty_count;

	cache_result_t due_results[$];
	cache_result_t want;

	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int mismatches = 0;
	int n_requests = 0;
	int n_results = 0;
	int cycle_count = 0;

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("sector_write_combine_cache_core_tb: done, errors");
			$finish;
		end
	end

	always @(posedge clk)
		rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);

	function automatic void push_result(logic [1:0] kind, logic [31:0] disk, logic [6:0] len,
			logic [5:0] off, logic rej, logic [31:0] val, logic fin);
		cache_result_t r;
		r.kind = kind;
		r.disk_sector = disk;
		r.run_length = len;
		r.buffer_offset = off;
		r.rejected = rej;
		r.reply_value = val;
		r.last = fin;
		due_results.push_back(r);
	endfunction

	function automatic bit in_window(logic [31:0] base, logic [31:0] size, logic [31:0] s,
			logic [1:0] c);
		logic [31:0] fin;
		logic [31:0] lim;
		fin = s + c;
		lim = base + size;
		return (base % size == 0) && (s >= base) && (fin <= lim);
	endfunction

	function automatic logic [31:0] window_base(logic [31:0] s, logic [1:0] c,
			logic [31:0] size);
		logic [31:0] b;
		logic [31:0] fin;
		logic [31:0] lim;
		b = s - s % size;
		fin = s + c;
		lim = b + size;
		if (fin > lim) begin
			b = s;
		end
		return b;
	endfunction

	// merge set bits into runs, lowest index first
	function automatic void flush_dirty();
		int run_start;
		int run_len;
		run_start = 0;
		run_len = 0;
		for (int i = 0; i <= WR_WIN; i++) begin
			if (i < WR_WIN && dirty_map[i]) begin
				if (run_len == 0) begin
					run_start = i;
				end
				run_len++;
			end else if (run_len != 0) begin
				push_result(KIND_RUN, wr_base + 32'(run_start), 7'(run_len), 6'(run_start),
					1'b0, 32'd0, 1'b0);
				run_len = 0;
			end
		end
		dirty_map = '0;
		dirty_count = '0;
	endfunction

	function automatic void compute_results(logic [2:0] f, logic [31:0] s, logic [1:0] c);
		logic [31:0] fin;
		logic [31:0] rd_end;
		logic [31:0] idx;
		fin = s + c;
		case (f)
			FUNC_STATUS: begin
				push_result(KIND_STATUS, 32'd0, 7'd0, 6'd0, 1'b0, cache_total, 1'b1);
			end
			FUNC_READ: begin
				if (!in_window(rd_base, RD_WIN, s, c)) begin
					if (dirty_count != 0) begin
						flush_dirty();
					end
					rd_base = window_base(s, c, RD_WIN);
					push_result(KIND_FILL, rd_base, 7'(RD_WIN), 6'd0, 1'b0, 32'd0, 1'b0);
				end
				push_result(KIND_DATA, 32'd0, 7'(c), 6'(s - rd_base), 1'b0, 32'd0, 1'b1);
			end
			FUNC_WRITE: begin
				// a write touching the read window, either end included, drops it
				rd_end = rd_base + RD_WIN;
				if ((s >= rd_base && s <= rd_end) || (fin >= rd_base && fin <= rd_end)) begin
					rd_base = EMPTY_BASE;
				end
				if (!in_window(wr_base, WR_WIN, s, c)) begin
					if (dirty_count != 0) begin
						flush_dirty();
					end
					wr_base = window_base(s, c, WR_WIN);
				end
				idx = s - wr_base;
				// only the first sector decides whether the write is new
				if (idx < WR_WIN && !dirty_map[idx[WR_IW-1:0]]) begin
					dirty_map[idx[WR_IW-1:0]] = 1'b1;
					if (c == 2 && idx + 1 < WR_WIN) begin
						dirty_map[idx[WR_IW-1:0] + 1'b1] = 1'b1;
					end
					dirty_count = dirty_count + c;
					if (dirty_count == WR_WIN) begin
						flush_dirty();
					end
				end
				push_result(KIND_STATUS, 32'd0, 7'd0, 6'd0, 1'b0, 32'd0, 1'b1);
			end
			FUNC_SYNC: begin
				flush_dirty();
				push_result(KIND_STATUS, 32'd0, 7'd0, 6'd0, 1'b0, 32'd0, 1'b1);
			end
			default: begin
				push_result(KIND_STATUS, 32'd0, 7'd0, 6'd0, 1'b1, 32'd0, 1'b1);
			end
		endcase
	endfunction

	function automatic void check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s: expected %0h, got %0h", name, exp_val, act_val);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			n_results++;
			if (due_results.size() == 0) begin
				$error("result word with nothing pending: kind %0d, sector %0h",
					rsp_ch.kind, rsp_ch.disk_sector);
				mismatches++;
			end else begin
				want = due_results.pop_front();
				check_field("kind", 32'(want.kind), 32'(rsp_ch.kind));
				check_field("disk_sector", want.disk_sector, rsp_ch.disk_sector);
				check_field("run_length", 32'(want.run_length), 32'(rsp_ch.run_length));
				check_field("buffer_offset", 32'(want.buffer_offset),
					32'(rsp_ch.buffer_offset));
				check_field("rejected", 32'(want.rejected), 32'(rsp_ch.rejected));
				check_field("reply_value", want.reply_value, rsp_ch.reply_value);
				check_field("last", 32'(want.last), 32'(rsp_ch.last));
			end
		end
	end

	task automatic send_req(input logic [2:0] f, input logic [31:0] s, input logic [1:0] c);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= f;
		req_ch.start_sector <= s;
		req_ch.sector_count <= c;
		do @(posedge clk); while (!req_ch.ready);
		compute_results(f, s, c);
		n_requests++;
	endtask

	// hold off until every pending word has come back and the sequencer is idle
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == TOTAL_ADDR) begin
			cache_total = data;
		end
	endtask

	task automatic test_status_and_rejects();
		send_req(FUNC_STATUS, 32'd0, 2'd0);
		drain();
		apb_write(TOTAL_ADDR, '1);
		send_req(FUNC_STATUS, $urandom, 2'($urandom_range(3)));
		send_req(FUNC_SHUTDOWN, '1, 2'd2);
		for (int f = FUNC_SHUTDOWN + 1; f <= FUNC_LAST; f++) begin
			send_req(3'(f), $urandom, 2'($urandom_range(3)));
		end
	endtask

	task automatic test_read_window();
		send_req(FUNC_READ, '1, 2'd2);
		send_req(FUNC_READ, '1, 2'd0);
		send_req(FUNC_READ, 32'd0, 2'd0);
		send_req(FUNC_READ, 32'd64, 2'd2);
		send_req(FUNC_READ, 32'd95, 2'd1);
		// crosses the window end, so the window starts at the request
		send_req(FUNC_READ, 32'd95, 2'd2);
		send_req(FUNC_READ, 32'd0, 2'd3);
	endtask

	task automatic test_write_combine();
		send_req(FUNC_WRITE, 32'd100, 2'd2);
		send_req(FUNC_WRITE, 32'd100, 2'd1);
		// count of zero at the window end: a hit that marks nothing
		send_req(FUNC_WRITE, 32'd128, 2'd0);
		send_req(FUNC_WRITE, 32'd110, 2'd3);
		send_req(FUNC_READ, 32'd64, 2'd1);
		send_req(FUNC_WRITE, 32'd70, 2'd1);
		send_req(FUNC_READ, 32'd65, 2'd1);
		send_req(FUNC_SYNC, 32'd0, 2'd0);
		send_req(FUNC_WRITE, '1, 2'd2);
		send_req(FUNC_SYNC, '1, 2'd3);
	endtask

	task automatic test_random_traffic(input int src_pct, input int sink_pct,
			input logic [31:0] total, input int n);
		int sent;
		int len;
		int pick;
		int tmp;
		int order [16];
		logic [31:0] hot;
		drain();
		apb_write(TOTAL_ADDR, total);
		src_idle_pct = src_pct;
		sink_stall_pct = sink_pct;
		sent = 0;
		while (sent < n) begin
			case ($urandom_range(7))
				5: hot = 32'($urandom_range(3)) * 32;
				6: hot = EMPTY_BASE - 31 - 32'($urandom_range(2)) * 32;
				7: hot = $urandom;
				default: hot = $urandom & ~32'd31;
			endcase
			case ($urandom_range(9))
				0, 1, 2: begin
					// fill a whole write window in random order
					for (int i = 0; i < 16; i++) order[i] = i;
					for (int i = 15; i > 0; i--) begin
						pick = $urandom_range(i);
						tmp = order[i];
						order[i] = order[pick];
						order[pick] = tmp;
					end
					for (int i = 0; i < 16; i++) begin
						send_req(FUNC_WRITE, hot + 2 * order[i],
							($urandom_range(19) == 0) ? 2'd1 : 2'd2);
					end
					sent += 16;
				end
				3, 4, 5: begin
					len = $urandom_range(3, 8);
					repeat (len) begin
						send_req(FUNC_WRITE, hot + $urandom_range(33),
							($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2)));
					end
					if ($urandom_range(1)) begin
						send_req(FUNC_READ, hot + $urandom_range(31), 2'($urandom_range(2)));
					end else begin
						send_req(FUNC_SYNC, $urandom, 2'($urandom_range(3)));
					end
					sent += len + 1;
				end
				6, 7: begin
					len = $urandom_range(2, 6);
					repeat (len) begin
						send_req(FUNC_READ, hot + $urandom_range(33), 2'($urandom_range(2)));
					end
					sent += len;
				end
				default: begin
					len = $urandom_range(1, 4);
					repeat (len) begin
						send_req(3'($urandom_range(7)), $urandom, 2'($urandom_range(3)));
					end
					sent += len;
				end
			endcase
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.func <= FUNC_STATUS;
		req_ch.start_sector <= '0;
		req_ch.sector_count <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		cache_total = '0;
		rd_base = EMPTY_BASE;
		wr_base = EMPTY_BASE;
		dirty_map = '0;
		dirty_count = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_status_and_rejects();
		test_read_window();
		test_write_combine();
		test_random_traffic(0, 0, $urandom, 52);
		test_random_traffic(66, 0, 32'd0, 52);
		test_random_traffic(0, 66, '1, 52);
		test_random_traffic(6, 6, $urandom, 52);
		drain();

		$display("%0d requests sent, %0d result words checked", n_requests, n_results);
		$display("covered status, rejects, read fills, write merging and full-window flushes");
		if (mismatches == 0 && due_results.size() == 0) begin
			$display("sector_write_combine_cache_core_tb: done, clean");
		end else begin
			$display("sector_write_combine_cache_core_tb: done, errors");
		end
		$finish;
	end

endmodule
